// ===== hdl/sup_pkg.sv =====
// shared types and constants for the 5-to-6 scanline upscaler
package sup_pkg;

  // palette geometry
  localparam int unsigned PAL_ENTRIES = 64;
  localparam int unsigned PAL_AW      = 6;
  localparam int unsigned COLOR_W     = 16;
  localparam int unsigned OUT_COL_W   = 9;

  // position of a source pixel within its group of five
  localparam logic [2:0] PH_A = 3'd0;
  localparam logic [2:0] PH_B = 3'd1;
  localparam logic [2:0] PH_C = 3'd2;
  localparam logic [2:0] PH_D = 3'd3;
  localparam logic [2:0] PH_E = 3'd4;

  // input item actions
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_PIXEL = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [COLOR_W-1:0]   pixel_color;
    logic [OUT_COL_W-1:0] out_column;
    logic                 row_done;
    logic                 last;
  } out_item_t;

endpackage

// ===== hdl/sup_ram.sv =====
// generic single-write, single-read ram with registered read data
module sup_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/sup_blend.sv =====
// per-channel floored blend of the previous and current source colors
module sup_blend (
  input  logic [sup_pkg::COLOR_W-1:0] prev_color,
  input  logic [sup_pkg::COLOR_W-1:0] cur_color,
  input  logic [2:0]                  phase,
  input  logic                        in_group,
  output logic [sup_pkg::COLOR_W-1:0] first_color,
  output logic                        two
);
  import sup_pkg::*;

  // weighted average of one channel, weights picked by group position
  function automatic logic [5:0] mix(input logic [5:0] x, input logic [5:0] y,
                                     input logic [2:0] ph);
    logic [7:0] xe;
    logic [7:0] ye;
    logic [7:0] s;
    xe = {2'b00, x};
    ye = {2'b00, y};
    case (ph) inside
      PH_B:       s = (xe + (ye << 1) + ye) >> 2;
      PH_C, PH_D: s = (xe + ye) >> 1;
      PH_E:       s = ((xe << 1) + xe + ye) >> 2;
      default:    s = ye;
    endcase
    return s[5:0];
  endfunction

  logic [2:0] ph_eff;
  logic [5:0] r_mix;
  logic [5:0] g_mix;
  logic [5:0] b_mix;

  // trailing pixels past the last full group are copied
  assign ph_eff = in_group ? phase : PH_A;

  assign r_mix = mix({1'b0, prev_color[15:11]}, {1'b0, cur_color[15:11]}, ph_eff);
  assign g_mix = mix(prev_color[10:5], cur_color[10:5], ph_eff);
  assign b_mix = mix({1'b0, prev_color[4:0]}, {1'b0, cur_color[4:0]}, ph_eff);

  assign first_color = {r_mix[4:0], g_mix, b_mix[4:0]};
  assign two         = (ph_eff == PH_E);

endmodule

// ===== hdl/scanline_upscale_5_to_6_top.sv =====
// top level of the 5-to-6 horizontal upscaler with rgb565 palette
//
// Load items write one palette entry (converted to rgb565) and give no result;
// one load is taken per cycle while src_stall is low. Pixel items go through
// a two-register pipeline: the palette ram read (registered) and then the
// blend into the output register. A pixel is taken in every cycle while the
// receiver does not stall, except that the fifth pixel of each full group of
// five gives two results, and the single result port hands them out one after
// the other; until the second is taken the read stage cannot advance. The
// palette resets to black through per-entry valid flags, so no clearing pass
// is needed.
module scanline_upscale_5_to_6_top #(
  parameter int unsigned ROW_PIXELS = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               src_valid,
  output logic               src_stall,
  input  sup_pkg::in_item_t  src_item,
  output logic               dst_valid,
  input  logic               dst_stall,
  output sup_pkg::out_item_t dst_item
);
  import sup_pkg::*;

  localparam int unsigned COL_W    = $clog2(ROW_PIXELS);
  localparam int unsigned FULL_END = (ROW_PIXELS / 5) * 5;
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_PIXELS - 1);
  localparam logic [COL_W:0]   FULL_END_C = (COL_W + 1)'(FULL_END);

  // input side stream position
  logic [COL_W-1:0]     col;
  logic [2:0]           phase;
  logic [OUT_COL_W-1:0] dest;
  logic [PAL_ENTRIES-1:0] entry_ok;

  // palette read stage
  logic                 s1_valid;
  logic                 s1_hit;
  logic [2:0]           s1_phase;
  logic                 s1_in_group;
  logic [OUT_COL_W-1:0] s1_dest;
  logic                 s1_row_end;

  // output register
  logic                 o_valid;
  logic                 o_two;
  logic                 o_second;
  logic [COLOR_W-1:0]   o_first;
  logic [COLOR_W-1:0]   o_color;
  logic [OUT_COL_W-1:0] o_dest;
  logic                 o_row_end;

  logic [COLOR_W-1:0] held_color;
  logic [COLOR_W-1:0] ram_data;
  logic [COLOR_W-1:0] cur_color;
  logic [COLOR_W-1:0] first_color;
  logic               two;

  logic src_acc;
  logic pix_acc;
  logic load_acc;
  logic dst_acc;
  logic o_done;
  logic s1_adv;
  logic row_end;
  logic [PAL_AW-1:0]  addr;
  logic [COLOR_W-1:0] load_color;

  // handshake
  assign src_acc  = src_valid && !src_stall;
  assign pix_acc  = src_acc && (src_item.action == ACT_PIXEL);
  assign load_acc = src_acc && (src_item.action == ACT_LOAD);
  assign dst_acc  = o_valid && !dst_stall;
  assign o_done   = dst_acc && (!o_two || o_second);
  assign s1_adv   = s1_valid && (!o_valid || o_done);
  assign src_stall = s1_valid && !s1_adv;

  assign addr       = src_item.index[PAL_AW-1:0];
  assign load_color = {src_item.red[7:3], src_item.green[7:2], src_item.blue[7:3]};
  assign row_end    = (col == LAST_COL);

  sup_ram #(
    .WIDTH (16),
    .DEPTH (64)
  ) u_palette (
    .clk     (clk),
    .wr_en   (load_acc),
    .wr_addr (addr),
    .wr_data (load_color),
    .rd_en   (pix_acc),
    .rd_addr (addr),
    .rd_data (ram_data)
  );

  // unwritten entries and double-aliased indices read as black
  assign cur_color = s1_hit ? ram_data : '0;

  sup_blend u_blend (
    .prev_color  (held_color),
    .cur_color   (cur_color),
    .phase       (s1_phase),
    .in_group    (s1_in_group),
    .first_color (first_color),
    .two         (two)
  );

  // palette valid flags and stream position
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_ok <= '0;
      col      <= '0;
      phase    <= PH_A;
      dest     <= '0;
    end else begin
      if (load_acc) begin
        entry_ok[addr] <= 1'b1;
      end
      if (pix_acc) begin
        if (row_end) begin
          col   <= '0;
          phase <= PH_A;
          dest  <= '0;
        end else begin
          col   <= col + 1'b1;
          phase <= (phase == PH_E) ? PH_A : phase + 3'd1;
          dest  <= dest + ((phase == PH_E) ? 9'd2 : 9'd1);
        end
      end
    end
  end

  // read stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pix_acc || (s1_valid && !s1_adv);
    end
    if (pix_acc) begin
      s1_hit      <= !(src_item.index[7] && src_item.index[6]) && entry_ok[addr];
      s1_phase    <= phase;
      s1_in_group <= ({1'b0, col} < FULL_END_C);
      s1_dest     <= dest;
      s1_row_end  <= row_end;
    end
  end

  // blend into the output register, second result follows the first
  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid    <= 1'b0;
      o_second   <= 1'b0;
      held_color <= '0;
    end else begin
      if (s1_adv) begin
        o_valid    <= 1'b1;
        o_second   <= 1'b0;
        held_color <= cur_color;
      end else if (o_done) begin
        o_valid  <= 1'b0;
        o_second <= 1'b0;
      end else if (dst_acc) begin
        o_second <= 1'b1;
      end
    end
    if (s1_adv) begin
      o_first   <= first_color;
      o_color   <= cur_color;
      o_two     <= two;
      o_dest    <= s1_dest;
      o_row_end <= s1_row_end;
    end
  end

  // result fields
  always_comb begin
    dst_item.pixel_color = o_second ? o_color : o_first;
    dst_item.out_column  = o_second ? o_dest + 9'd1 : o_dest;
    dst_item.row_done    = o_row_end && (!o_two || o_second);
    dst_item.last        = !o_two || o_second;
  end
  assign dst_valid = o_valid;

endmodule

// ===== hdl/sup_checker.sv =====
// port-level checks for the upscaler and their binding
module sup_checker (
  input logic               clk,
  input logic               rst,
  input logic               src_stall,
  input logic               dst_valid,
  input logic               dst_stall,
  input sup_pkg::out_item_t dst_item
);
  import sup_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_stall |=> dst_valid && $stable(dst_item))
    else $error("stalled result changed");

  // row end only on the last result of an item
  a_row_last: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_item.row_done |-> dst_item.last)
    else $error("row_done without last");

  // the second result of a pair is ready right after the first
  a_pair_next: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_stall && !dst_item.last |=> dst_valid)
    else $error("second result missing");

  // the second result of a pair lands in the next column
  a_pair_col: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_stall && !dst_item.last |=>
      dst_item.out_column == OUT_COL_W'($past(dst_item.out_column) + 1'b1))
    else $error("pair column mismatch");

  // the input is only held off while a result is waiting
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    src_stall |-> dst_valid)
    else $error("input stalled with no result pending");

endmodule

bind scanline_upscale_5_to_6_top sup_checker u_sup_checker (
  .clk       (clk),
  .rst       (rst),
  .src_stall (src_stall),
  .dst_valid (dst_valid),
  .dst_stall (dst_stall),
  .dst_item  (dst_item)
);
